// ===== rtl/aaao_pkg.sv =====
// Package for the array atomic ALU engine: operation and status codes, widths.
// No dependencies.
package aaao_pkg;

  localparam int unsigned DepthDef = 256;
  localparam int unsigned WordW    = 32;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpPow = 3'd4;

  localparam logic [1:0] StOk         = 2'd0;
  localparam logic [1:0] StDivZero    = 2'd1;
  localparam logic [1:0] StZeroBaseEx = 2'd2;
  localparam logic [1:0] StProdZero   = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_SRC, S_EXEC, S_DIV, S_POW_MUL, S_POW_SQ, S_FIN, S_OUT
  } state_e;

endpackage

// ===== rtl/aaao_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module aaao_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/array_atomic_alu_ops.sv =====
// Top level of the array atomic ALU engine: sequencer, RAM, divider, power unit.
// Depends on aaao_pkg and aaao_ram.
//
// Channel  | Dir | Content
// s_axis   | in  | tdata: operation, target_index, operand_from_entry, source_index, immediate
// m_axis   | out | tdata: new_value, status
//
// Add/sub/mul pass through accept, two RAM reads, execute, write back and output; divide
// adds a divide step (one quotient bit a cycle); power adds a multiply, then a square,
// per exponent bit.
// After reset a clearing pass over every RAM row (ARRAY_DEPTH rounded up to a power
// of two) runs before the first transfer.
// One item at a time; a result held in the output register stalls only the output
// step of the next item until it is taken.
module array_atomic_alu_ops
  import aaao_pkg::*;
#(
  parameter int unsigned ARRAY_DEPTH = DepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] operation, [10:3] target_index, [11] operand_from_entry,
  // [19:12] source_index, [51:20] immediate_value, [55:52] zero
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] new_value, [33:32] status, [39:34] zero
  output logic [39:0] m_axis_tdata_o
);
  localparam int unsigned AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int unsigned RD = 1 << AW;

  state_e state_q, state_d;
  logic [AW:0]   clr_q, clr_d;
  logic [2:0]    op_q, op_d;
  logic [7:0]    tgt_q, tgt_d, src_q, src_d;
  logic          fe_q, fe_d;
  logic [31:0]   imm_q, imm_d;
  logic [31:0]   left_q, left_d, right_q, right_d;
  logic [31:0]   res_q, res_d;
  logic [1:0]    st_q, st_d;
  logic          store_q, store_d;
  logic [31:0]   acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic [31:0]   quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          ovalid_q, ovalid_d;
  logic [33:0]   odata_q, odata_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  aaao_ram #(.Width(WordW), .Depth(RD)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic [31:0] mag(input logic [31:0] a);
    return a[31] ? (32'd0 - a) : a;
  endfunction

  function automatic logic in_rng(input logic [7:0] i);
    return {24'd0, i} < ARRAY_DEPTH;
  endfunction

  logic [31:0] mul_p;
  logic [31:0] mul_a, mul_b;
  assign mul_p = mul_a * mul_b;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; tgt_q <= tgt_d; src_q <= src_d; fe_q <= fe_d; imm_q <= imm_d;
    left_q <= left_d; right_q <= right_d; res_q <= res_d; st_q <= st_d;
    store_q <= store_d; acc_q <= acc_d; base_q <= base_d; exp_q <= exp_d;
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d; cnt_q <= cnt_d;
    odata_q <= odata_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'd0, odata_q};

  always_comb begin
    state_d = state_q; clr_d = clr_q;
    op_d = op_q; tgt_d = tgt_q; src_d = src_q; fe_d = fe_q; imm_d = imm_q;
    left_d = left_q; right_d = right_q; res_d = res_q; st_d = st_q;
    store_d = store_q; acc_d = acc_q; base_d = base_q; exp_d = exp_q;
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    we = 1'b0; addr = AW'(tgt_q); wdata = res_q;
    mul_a = left_q; mul_b = right_q;
    if (ovalid_q && m_axis_tready_i) ovalid_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1; addr = clr_q[AW-1:0]; wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW + 1)'(RD - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d  = s_axis_tdata_i[2:0];
          tgt_d = s_axis_tdata_i[10:3];
          fe_d  = s_axis_tdata_i[11];
          src_d = s_axis_tdata_i[19:12];
          imm_d = s_axis_tdata_i[51:20];
          addr  = AW'(s_axis_tdata_i[19:12]);
          state_d = S_READ;
        end
      end
      S_READ: begin
        // rdata holds source entry; now read target
        right_d = fe_q ? (in_rng(src_q) ? rdata : 32'd0) : imm_q;
        addr = AW'(tgt_q);
        state_d = S_SRC;
      end
      S_SRC: begin
        left_d = in_rng(tgt_q) ? rdata : 32'd0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        res_d = left_q; st_d = StOk; store_d = 1'b0;
        state_d = S_FIN;
        case (op_q)
          OpAdd: begin res_d = left_q + right_q; store_d = 1'b1; end
          OpSub: begin res_d = left_q - right_q; store_d = 1'b1; end
          OpMul: begin res_d = mul_p[31:0]; store_d = 1'b1; end
          OpDiv: begin
            if (right_q == '0) st_d = StDivZero;
            else begin
              quo_d = mag(left_q); rem_d = '0; dvs_d = mag(right_q);
              cnt_d = '0; state_d = S_DIV;
            end
          end
          OpPow: begin
            if (left_q == '0 || right_q == '0) st_d = StZeroBaseEx;
            else begin
              acc_d = 32'd1; base_d = left_q; exp_d = mag(right_q);
              state_d = S_POW_MUL;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (!rem_sub[32]) begin
          rem_d = rem_sub[31:0]; quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0]; quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd31) begin
          res_d = (left_q[31] ^ right_q[31]) ? (32'd0 - quo_d) : quo_d;
          store_d = 1'b1;
          state_d = S_FIN;
        end
      end
      S_POW_MUL: begin
        mul_a = acc_q; mul_b = base_q;
        if (exp_q[0]) acc_d = mul_p[31:0];
        state_d = S_POW_SQ;
      end
      S_POW_SQ: begin
        mul_a = base_q; mul_b = base_q;
        base_d = mul_p[31:0];
        exp_d = exp_q >> 1;
        if (exp_d == '0) begin
          store_d = 1'b1;
          if (acc_q == '0) begin res_d = '0; st_d = StProdZero; end
          else if (right_q[31]) begin
            res_d = (acc_q == 32'd1) ? 32'd1 : (acc_q == 32'hFFFF_FFFF) ? acc_q : 32'd0;
            st_d = StOk;
          end else begin res_d = acc_q; st_d = StOk; end
          state_d = S_FIN;
        end else state_d = S_POW_MUL;
      end
      S_FIN: begin
        we = store_q && in_rng(tgt_q);
        addr = AW'(tgt_q); wdata = res_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1; odata_d = {st_q, res_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ===== tb/tb.sv =====
// Testbench for array_atomic_alu_ops: drives read-modify-write commands on the
// input stream and checks every result against a local array/ALU predictor.
// Depends on aaao_pkg and the RTL of array_atomic_alu_ops.
`timescale 1ns / 100ps

module tb
  import aaao_pkg::*;
();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  array_atomic_alu_ops dut (.*);

  always #6 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } alu_result_t;

  logic [31:0]  shadow_array [DepthDef];
  alu_result_t  pending_results [$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           sink_idle_on = 1'b1;
  bit           src_idle_on = 1'b1;
  int           hold_cycles = 0;
  int           sink_gap = 0;

  function automatic logic [31:0] abs32(logic [31:0] a);
    return a[31] ? 32'd0 - a : a;
  endfunction

  function automatic logic [31:0] power_by_squaring(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc;
    acc = 32'd1;
    while (e != 0) begin
      if (e[0]) acc = acc * b;
      b = b * b;
      e = e >> 1;
    end
    return acc;
  endfunction

  // Predicts one command against the shadow array and updates it.
  function automatic alu_result_t apply_command(logic [2:0] op, logic [7:0] tgt,
                                                logic from_entry, logic [7:0] src,
                                                logic [31:0] imm);
    logic [31:0] lhs, rhs, res, prod;
    logic [1:0]  st;
    bit          wr;
    lhs = shadow_array[tgt];
    rhs = from_entry ? shadow_array[src] : imm;
    res = lhs; st = StOk; wr = 1'b0;
    case (op)
      OpAdd: begin res = lhs + rhs; wr = 1; end
      OpSub: begin res = lhs - rhs; wr = 1; end
      OpMul: begin res = lhs * rhs; wr = 1; end
      OpDiv: begin
        if (rhs == 0) st = StDivZero;
        else begin
          res = abs32(lhs) / abs32(rhs);
          if (lhs[31] ^ rhs[31]) res = 32'd0 - res;
          wr = 1;
        end
      end
      OpPow: begin
        if (lhs == 0 || rhs == 0) st = StZeroBaseEx;
        else begin
          prod = power_by_squaring(lhs, abs32(rhs));
          wr = 1;
          if (prod == 0) begin res = 0; st = StProdZero; end
          else if (rhs[31]) res = (prod == 32'd1 || prod == 32'hFFFF_FFFF) ? prod : 32'd0;
          else res = prod;
        end
      end
      default: ;
    endcase
    if (wr) shadow_array[tgt] = res;
    return '{value: res, status: st};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // tvalid stays high across commands except in random gaps; the caller drops it.
  task automatic send_command(logic [2:0] op, logic [7:0] tgt, logic from_entry,
                              logic [7:0] src, logic [31:0] imm);
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, imm, src, from_entry, tgt, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(apply_command(op, tgt, from_entry, src, imm));
  endtask

  // Sink: random stall bursts, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_idle_on && sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 10);
      m_axis_tready_i <= 1'b0;
    end else
      m_axis_tready_i <= 1'b1;
  end

  // Result checker
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0)
        report_mismatch("unexpected transfer", m_axis_tdata_o[31:0], 32'd0);
      else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[31:0] !== want.value)
          report_mismatch("new_value", m_axis_tdata_o[31:0], want.value);
        if (m_axis_tdata_o[33:32] !== want.status)
          report_mismatch("status", {30'd0, m_axis_tdata_o[33:32]}, {30'd0, want.status});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 800000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4);
      1: return 32'd0 - $urandom_range(1, 4);
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_command(OpPow, 8'd0, 1'b0, 8'd0, 32'd3);          // zero base
    send_command(OpDiv, 8'd0, 1'b0, 8'd0, 32'd0);          // divide by zero
    send_command(OpAdd, 8'd0, 1'b0, 8'd0, 32'h8000_0000);
    send_command(OpDiv, 8'd0, 1'b0, 8'd0, 32'hFFFF_FFFF);  // min / -1
    send_command(OpAdd, 8'd255, 1'b0, 8'd0, 32'h7FFF_FFFF);
    send_command(OpAdd, 8'd255, 1'b0, 8'd0, 32'd1);        // wrap
    send_command(OpSub, 8'd1, 1'b0, 8'd0, 32'd7);
    send_command(OpMul, 8'd1, 1'b0, 8'd0, 32'hFFFF_FFFD);
    send_command(OpDiv, 8'd1, 1'b0, 8'd0, 32'd4);          // truncation
    send_command(OpAdd, 8'd2, 1'b0, 8'd0, 32'd3);
    send_command(OpPow, 8'd2, 1'b0, 8'd0, 32'd0);          // zero exponent
    send_command(OpPow, 8'd2, 1'b0, 8'd0, 32'd5);
    send_command(OpPow, 8'd2, 1'b0, 8'd0, 32'hFFFF_FFFF);  // negative exponent
    send_command(OpAdd, 8'd3, 1'b0, 8'd0, 32'hFFFF_FFFF);
    send_command(OpPow, 8'd3, 1'b0, 8'd0, 32'hFFFF_FFFD);  // -1 ^ -3
    send_command(OpAdd, 8'd4, 1'b0, 8'd0, 32'd1);
    send_command(OpPow, 8'd4, 1'b0, 8'd0, 32'h8000_0000);  // most negative exponent
    send_command(OpAdd, 8'd5, 1'b0, 8'd0, 32'd2);
    send_command(OpPow, 8'd5, 1'b1, 8'd5, 32'd0);          // exponent is the target
    send_command(OpPow, 8'd5, 1'b0, 8'd0, 32'd40);         // product wraps to zero
    send_command(OpAdd, 8'd6, 1'b1, 8'd255, 32'd0);
    send_command(3'd5, 8'd6, 1'b1, 8'd170, 32'hFFFF_FFFF); // unused codes
    send_command(3'd7, 8'd85, 1'b0, 8'd85, 32'd0);
    send_command(3'd6, 8'd6, 1'b0, 8'd0, 32'h5555_AAAA);
  endtask

  task automatic test_random(int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_command(op, 8'($urandom_range(0, 15)) | (($urandom_range(0, 7) == 0) ? 8'($urandom)
                   : 8'd0), 1'($urandom), 8'($urandom_range(0, 15)) |
                   (($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0), pick_value());
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 10; i++)
      send_command(OpAdd, 8'($urandom_range(0, 15)), 1'b0, 8'd0, $urandom);
  endtask

  initial begin
    foreach (shadow_array[k]) shadow_array[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(350);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(150);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
